FILE: hdl/lttd_pkg.sv
// ----------------------------------------------------------------------------
// lttd_pkg
// Shared types, constants and the checksum step of the telegram deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lttd_pkg;

   // input word kinds (req_tuser)
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // register indexes on the csr port
   localparam logic CSR_FRAME_ADDRESS = 1'b0;
   localparam logic CSR_BODY_TIMEOUT  = 1'b1;

   localparam logic [7:0]  STX_BYTE       = 8'h02;
   localparam logic [15:0] CHK_POLY       = 16'h8005;
   localparam int          HDR_BYTES      = 4;
   localparam int          OVERHEAD_BYTES = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDATA,
      ST_LOOP,
      ST_HDR_A,
      ST_HDR_B,
      ST_HDR_CHK,
      ST_CRC_A,
      ST_CRC_B,
      ST_CRC_CHK,
      ST_RS_A,
      ST_RS_B,
      ST_CP_A,
      ST_CP_B,
      ST_OUT
   } state_type;

   // one checksum step: shift with feedback, then fold in the byte window
   function automatic logic [15:0] chk_step(input logic [15:0] c, input logic [15:0] w);
      logic [15:0] s;
      s = c[15] ? ({c[14:0], 1'b0} ^ CHK_POLY) : {c[14:0], 1'b0};
      return s ^ w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/lttd_ram.sv
// ----------------------------------------------------------------------------
// lttd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lttd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

FILE: hdl/laser_telegram_receive_deframer.sv
// ----------------------------------------------------------------------------
// laser_telegram_receive_deframer
// Buffers received serial bytes into telegrams, checks header and checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per event: a received byte, a time tick or a read
//   of the accepted frame (kind in req_tuser). Every request word gives exactly
//   one rsp_* word with the good/failed/timeout flags, command, length and
//   read data. csr_* writes the frame address and the body timeout.
// Sequencing:
//   One word is worked on at a time. A byte that leaves fewer than 4 bytes
//   buffered is answered without a header read; a byte that leaves a body
//   incomplete re-reads the header. A byte that completes a frame walks the
//   buffer through the single RAM read port. A resync scan reads each byte
//   searched and moves the remaining bytes down, and each new candidate
//   re-reads its header.
// Reset:
//   Synchronous; the buffer is empty, control registers take their defaults.
//   The frame RAM is not cleared: no read of an unwritten entry is expected.
// Stall:
//   A finished result sits in the output register while rsp_tready is low;
//   the next request is taken, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_telegram_receive_deframer #(
   parameter int MAX_FRAME_BYTES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // [7:0] rx_byte, [17:8] read_index
   input  wire logic [1:0]  req_tuser,  // [1:0] kind
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [7:0] command_byte, [17:8] payload_count,
                                        // [25:18] read_data
   output logic      [2:0]  rsp_tuser,  // [0] frame_good, [1] checksum_failed,
                                        // [2] timed_out
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW = $clog2(MAX_FRAME_BYTES);
   localparam int PW = AW + 1;

   lttd_pkg::state_type state_ff, state_in;

   logic [PW-1:0] fill_ff, fill_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] src_ff, src_in;
   logic [PW-1:0] shift_ff, shift_in;
   logic [15:0]   idle_ff, idle_in;
   logic [7:0]    addr_cfg_ff;
   logic [15:0]   tmo_cfg_ff;

   // header and checksum working registers
   logic [7:0]  b0_ff, b0_in;
   logic [7:0]  b1_ff, b1_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] win_ff, win_in;
   logic [15:0] got_ff, got_in;
   logic [7:0]  cmd_ff, cmd_in;

   // pending result
   logic       good_ff, good_in;
   logic       bad_ff, bad_in;
   logic       tmo_ff, tmo_in;
   logic [7:0] rd_ff, rd_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   // RAM port
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic        accept;
   logic [1:0]  kind;
   logic [7:0]  rx_byte;
   logic [9:0]  read_index;
   logic [15:0] win_nx;
   logic [15:0] idle_nx;
   logic [15:0] tmo_thr;

   assign kind       = req_tuser;
   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[17:8];
   assign req_tready = (state_ff == lttd_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign win_nx     = {win_ff[7:0], ram_rdata};
   assign idle_nx    = (idle_ff == 16'hffff) ? idle_ff : idle_ff + 16'd1;
   assign tmo_thr    = (tmo_cfg_ff == 16'd0) ? 16'd1 : tmo_cfg_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   lttd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_cfg_ff <= 8'h80;
         tmo_cfg_ff  <= 16'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            lttd_pkg::CSR_FRAME_ADDRESS: addr_cfg_ff <= csr_wdata[7:0];
            lttd_pkg::CSR_BODY_TIMEOUT:  tmo_cfg_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lttd_pkg::ST_IDLE;
         fill_ff      <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      src_ff      <= src_in;
      shift_ff    <= shift_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      len_ff      <= len_in;
      crc_ff      <= crc_in;
      win_ff      <= win_in;
      got_ff      <= got_in;
      cmd_ff      <= cmd_in;
      good_ff     <= good_in;
      bad_ff      <= bad_in;
      tmo_ff      <= tmo_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idle_in      = idle_ff;
      ptr_in       = ptr_ff;
      src_in       = src_ff;
      shift_in     = shift_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      win_in       = win_ff;
      got_in       = got_ff;
      cmd_in       = cmd_ff;
      good_in      = good_ff;
      bad_in       = bad_ff;
      tmo_in       = tmo_ff;
      rd_in        = rd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[AW-1:0];
      ram_wdata    = rx_byte;
      ram_raddr    = ptr_ff[AW-1:0];

      unique case (state_ff)
         lttd_pkg::ST_IDLE: begin
            if (accept) begin
               good_in  = 1'b0;
               bad_in   = 1'b0;
               tmo_in   = 1'b0;
               rd_in    = 8'd0;
               state_in = lttd_pkg::ST_OUT;
               unique case (kind)
                  lttd_pkg::KIND_BYTE: begin
                     if (32'(fill_ff) < MAX_FRAME_BYTES) begin
                        ram_we  = 1'b1;
                        fill_in = fill_ff + PW'(1);
                     end else begin
                        fill_in = '0;
                     end
                     idle_in  = '0;
                     state_in = lttd_pkg::ST_LOOP;
                  end
                  lttd_pkg::KIND_TICK: begin
                     if (32'(fill_ff) >= lttd_pkg::HDR_BYTES) begin
                        if (idle_nx >= tmo_thr) begin
                           tmo_in  = 1'b1;
                           fill_in = '0;
                           idle_in = '0;
                        end else begin
                           idle_in = idle_nx;
                        end
                     end else begin
                        idle_in = '0;
                     end
                  end
                  lttd_pkg::KIND_READ: begin
                     ram_raddr = AW'(read_index);
                     if (32'(read_index) < MAX_FRAME_BYTES) begin
                        state_in = lttd_pkg::ST_RDATA;
                     end
                  end
                  default: ;
               endcase
            end
         end

         lttd_pkg::ST_RDATA: begin
            rd_in    = ram_rdata;
            state_in = lttd_pkg::ST_OUT;
         end

         // top of the candidate loop
         lttd_pkg::ST_LOOP: begin
            if (32'(fill_ff) < lttd_pkg::HDR_BYTES) begin
               state_in = lttd_pkg::ST_OUT;
            end else begin
               ptr_in   = '0;
               crc_in   = '0;
               win_in   = '0;
               state_in = lttd_pkg::ST_HDR_A;
            end
         end

         lttd_pkg::ST_HDR_A: begin
            state_in = lttd_pkg::ST_HDR_B;
         end

         // header bytes also feed the checksum
         lttd_pkg::ST_HDR_B: begin
            case (ptr_ff[1:0])
               2'd0:    b0_in = ram_rdata;
               2'd1:    b1_in = ram_rdata;
               2'd2:    len_in[7:0] = ram_rdata;
               default: len_in[15:8] = ram_rdata;
            endcase
            win_in = win_nx;
            crc_in = lttd_pkg::chk_step(crc_ff, win_nx);
            ptr_in = ptr_ff + PW'(1);
            state_in = (ptr_ff[1:0] == 2'd3) ? lttd_pkg::ST_HDR_CHK : lttd_pkg::ST_HDR_A;
         end

         lttd_pkg::ST_HDR_CHK: begin
            if (b0_ff != lttd_pkg::STX_BYTE || b1_ff != addr_cfg_ff ||
                32'(len_ff) >= MAX_FRAME_BYTES - lttd_pkg::OVERHEAD_BYTES) begin
               ptr_in   = PW'(1);
               state_in = lttd_pkg::ST_RS_A;
            end else if (32'(fill_ff) < 32'(len_ff) + lttd_pkg::OVERHEAD_BYTES) begin
               state_in = lttd_pkg::ST_OUT;
            end else begin
               state_in = lttd_pkg::ST_CRC_A;
            end
         end

         lttd_pkg::ST_CRC_A: begin
            state_in = lttd_pkg::ST_CRC_B;
         end

         // payload into the checksum, then the two stored checksum bytes
         lttd_pkg::ST_CRC_B: begin
            if (32'(ptr_ff) == lttd_pkg::HDR_BYTES) begin
               cmd_in = ram_rdata;
            end
            ptr_in   = ptr_ff + PW'(1);
            state_in = lttd_pkg::ST_CRC_A;
            if (32'(ptr_ff) < 32'(len_ff) + lttd_pkg::HDR_BYTES) begin
               win_in = win_nx;
               crc_in = lttd_pkg::chk_step(crc_ff, win_nx);
            end else if (32'(ptr_ff) == 32'(len_ff) + lttd_pkg::HDR_BYTES) begin
               got_in[7:0] = ram_rdata;
            end else begin
               got_in[15:8] = ram_rdata;
               state_in     = lttd_pkg::ST_CRC_CHK;
            end
         end

         lttd_pkg::ST_CRC_CHK: begin
            if (got_ff == crc_ff) begin
               good_in  = 1'b1;
               fill_in  = '0;
               state_in = lttd_pkg::ST_OUT;
            end else begin
               bad_in   = 1'b1;
               ptr_in   = PW'(1);
               state_in = lttd_pkg::ST_RS_A;
            end
         end

         // resync: search for the next start byte
         lttd_pkg::ST_RS_A: begin
            if (ptr_ff >= fill_ff) begin
               fill_in  = '0;
               state_in = lttd_pkg::ST_LOOP;
            end else begin
               state_in = lttd_pkg::ST_RS_B;
            end
         end

         lttd_pkg::ST_RS_B: begin
            if (ram_rdata == lttd_pkg::STX_BYTE) begin
               shift_in = ptr_ff;
               src_in   = ptr_ff;
               state_in = lttd_pkg::ST_CP_A;
            end else begin
               ptr_in   = ptr_ff + PW'(1);
               state_in = lttd_pkg::ST_RS_A;
            end
         end

         // move the remaining bytes down to offset zero
         lttd_pkg::ST_CP_A: begin
            ram_raddr = src_ff[AW-1:0];
            if (src_ff >= fill_ff) begin
               fill_in  = fill_ff - shift_ff;
               state_in = lttd_pkg::ST_LOOP;
            end else begin
               state_in = lttd_pkg::ST_CP_B;
            end
         end

         lttd_pkg::ST_CP_B: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(src_ff - shift_ff);
            ram_wdata = ram_rdata;
            src_in    = src_ff + PW'(1);
            state_in  = lttd_pkg::ST_CP_A;
         end

         // hand the result to the output register
         lttd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {tmo_ff, bad_ff, good_ff};
               rsp_data_in  = {6'd0, rd_ff,
                               good_ff ? len_ff[9:0] : 10'd0,
                               good_ff ? cmd_ff : 8'd0};
               state_in     = lttd_pkg::ST_IDLE;
            end
         end

         default: state_in = lttd_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire
